// ===== rtl/core/mtd_pkg.sv =====
// ----------------------------------------------------------------------------
// mtd_pkg
// Shared types, constants and the Morse lookup table for the text decoder.
// ----------------------------------------------------------------------------
package mtd_pkg;

    localparam int MAX_CODE_LENGTH_DEF = 9;
    localparam int QUEUE_DEPTH_DEF     = 4;

    localparam logic [2:0] WORD_GAP_RESET = 3'd3;
    localparam logic [2:0] WORD_GAP_MIN   = 3'd2;
    localparam logic [2:0] SPACE_RUN_MAX  = 3'd7;
    localparam logic [6:0] SPACE_CHAR     = 7'h20;
    localparam logic [6:0] NO_CHAR        = 7'h00;
    localparam int         TABLE_BITS     = 6;

    localparam logic [1:0] KIND_DOT   = 2'd0;
    localparam logic [1:0] KIND_DASH  = 2'd1;
    localparam logic [1:0] KIND_SPACE = 2'd2;

    typedef struct packed {
        logic [1:0] symbol_kind;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [6:0] char_code;
        logic       last_char;
    } out_item_t;

    // One or two result items caused by one input item.
    typedef struct packed {
        logic       two;
        logic [6:0] ch_a;
        logic [6:0] ch_b;
        logic       last;
    } entry_t;

    function automatic logic [6:0] morse_lookup(input logic [3:0] len,
                                                input logic [TABLE_BITS-1:0] bits);
        logic [6:0] ch;
        ch = NO_CHAR;
        unique case ({len, bits})
            {4'd2, 6'h01}: ch = 7'h41; // A
            {4'd4, 6'h08}: ch = 7'h42;
            {4'd4, 6'h0A}: ch = 7'h43;
            {4'd3, 6'h04}: ch = 7'h44;
            {4'd1, 6'h00}: ch = 7'h45;
            {4'd4, 6'h02}: ch = 7'h46;
            {4'd3, 6'h06}: ch = 7'h47;
            {4'd4, 6'h00}: ch = 7'h48;
            {4'd2, 6'h00}: ch = 7'h49;
            {4'd4, 6'h07}: ch = 7'h4A;
            {4'd3, 6'h05}: ch = 7'h4B;
            {4'd4, 6'h04}: ch = 7'h4C;
            {4'd2, 6'h03}: ch = 7'h4D;
            {4'd2, 6'h02}: ch = 7'h4E;
            {4'd3, 6'h07}: ch = 7'h4F;
            {4'd4, 6'h06}: ch = 7'h50;
            {4'd4, 6'h0D}: ch = 7'h51;
            {4'd3, 6'h02}: ch = 7'h52;
            {4'd3, 6'h00}: ch = 7'h53;
            {4'd1, 6'h01}: ch = 7'h54;
            {4'd3, 6'h01}: ch = 7'h55;
            {4'd4, 6'h01}: ch = 7'h56;
            {4'd3, 6'h03}: ch = 7'h57;
            {4'd4, 6'h09}: ch = 7'h58;
            {4'd4, 6'h0B}: ch = 7'h59;
            {4'd4, 6'h0C}: ch = 7'h5A; // Z
            {4'd5, 6'h1F}: ch = 7'h30; // 0
            {4'd5, 6'h0F}: ch = 7'h31;
            {4'd5, 6'h07}: ch = 7'h32;
            {4'd5, 6'h03}: ch = 7'h33;
            {4'd5, 6'h01}: ch = 7'h34;
            {4'd5, 6'h00}: ch = 7'h35;
            {4'd5, 6'h10}: ch = 7'h36;
            {4'd5, 6'h18}: ch = 7'h37;
            {4'd5, 6'h1C}: ch = 7'h38;
            {4'd5, 6'h1E}: ch = 7'h39; // 9
            {4'd6, 6'h15}: ch = 7'h2E; // .
            {4'd6, 6'h33}: ch = 7'h2C; // ,
            {4'd6, 6'h0C}: ch = 7'h3F; // ?
            {4'd6, 6'h1E}: ch = 7'h27; // '
            {4'd6, 6'h2B}: ch = 7'h21; // !
            {4'd5, 6'h12}: ch = 7'h2F; // /
            {4'd5, 6'h16}: ch = 7'h28; // (
            {4'd6, 6'h2D}: ch = 7'h29; // )
            {4'd6, 6'h38}: ch = 7'h3A; // :
            {4'd6, 6'h2A}: ch = 7'h3B; // ;
            {4'd5, 6'h11}: ch = 7'h3D; // =
            {4'd6, 6'h21}: ch = 7'h2D; // -
            {4'd6, 6'h0D}: ch = 7'h5F; // _
            {4'd6, 6'h12}: ch = 7'h22; // "
            {4'd6, 6'h1A}: ch = 7'h40; // @
            default:       ch = NO_CHAR;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/core/morse_text_decoder.sv =====
// ----------------------------------------------------------------------------
// morse_text_decoder: Morse symbol stream to ASCII characters
// Takes one symbol item per cycle while the entry queue is not full. A result
// item passes through the entry queue and the two-result serializer, and one
// result item leaves per cycle while pop is held and results are waiting.
// Reset clears all decode state and sets the word gap to three spaces.
// ----------------------------------------------------------------------------
module morse_text_decoder #(
    parameter int MAX_CODE_LENGTH = mtd_pkg::MAX_CODE_LENGTH_DEF,
    parameter int QUEUE_DEPTH     = mtd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  mtd_pkg::in_item_t  symbol,
    output logic               empty,
    input  logic               pop,
    output mtd_pkg::out_item_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_data
);

    logic            wr_en;
    mtd_pkg::entry_t wr_entry;
    logic            rd_en;
    mtd_pkg::entry_t rd_entry;
    logic            queue_empty;

    assign cfg_ready = 1'b1;

    mtd_front #(
        .MAX_CODE_LENGTH(MAX_CODE_LENGTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .symbol    (symbol),
        .queue_full(full),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .wr_en     (wr_en),
        .wr_entry  (wr_entry)
    );

    mtd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_entry(wr_entry),
        .full    (full),
        .rd_en   (rd_en),
        .rd_entry(rd_entry),
        .empty   (queue_empty)
    );

    mtd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_entry   (rd_entry),
        .queue_empty(queue_empty),
        .rd_en      (rd_en),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

endmodule

// ===== rtl/core/mtd_front.sv =====
// ----------------------------------------------------------------------------
// mtd_front
// Accepts symbols, builds the code, tracks word gaps and forms result entries.
// ----------------------------------------------------------------------------
module mtd_front #(
    parameter int MAX_CODE_LENGTH = mtd_pkg::MAX_CODE_LENGTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mtd_pkg::in_item_t symbol,
    input  logic              queue_full,
    input  logic              cfg_valid,
    input  logic [2:0]        cfg_data,
    output logic              wr_en,
    output mtd_pkg::entry_t   wr_entry
);

    localparam logic [3:0] MAX_LEN = 4'(MAX_CODE_LENGTH);

    logic [MAX_CODE_LENGTH-1:0] code_bits_reg, code_bits_next;
    logic [3:0]                 code_length_reg, code_length_next;
    logic                       code_overflow_reg, code_overflow_next;
    logic [2:0]                 space_run_reg, space_run_next;
    logic                       gap_pending_reg, gap_pending_next;
    logic                       word_seen_reg, word_seen_next;
    logic [2:0]                 word_gap_reg;

    logic                       accept;
    logic                       is_mark;
    logic                       is_space;
    logic [2:0]                 gap_eff;
    logic [MAX_CODE_LENGTH-1:0] lk_bits;
    logic [3:0]                 lk_len;
    logic                       lk_ovf;
    logic [6:0]                 ch;
    logic                       space_emit;
    logic                       letter_emit;

    assign accept   = push && !queue_full;
    assign is_mark  = (symbol.symbol_kind == mtd_pkg::KIND_DOT) ||
                      (symbol.symbol_kind == mtd_pkg::KIND_DASH);
    assign is_space = (symbol.symbol_kind == mtd_pkg::KIND_SPACE);
    assign gap_eff  = (word_gap_reg < mtd_pkg::WORD_GAP_MIN) ? mtd_pkg::WORD_GAP_MIN
                                                             : word_gap_reg;

    always_comb
    begin
        code_bits_next     = code_bits_reg;
        code_length_next   = code_length_reg;
        code_overflow_next = code_overflow_reg;
        space_run_next     = space_run_reg;
        gap_pending_next   = gap_pending_reg;
        word_seen_next     = word_seen_reg;

        if (is_mark)
        begin
            if (code_length_reg < MAX_LEN)
            begin
                code_bits_next   = {code_bits_reg[MAX_CODE_LENGTH-2:0],
                                    symbol.symbol_kind[0]};
                code_length_next = code_length_reg + 4'd1;
            end
            else
            begin
                code_overflow_next = 1'b1;
            end
        end

        // Space decodes the letter in hand; otherwise end of message sees the updated code.
        lk_bits = is_space ? code_bits_reg     : code_bits_next;
        lk_len  = is_space ? code_length_reg   : code_length_next;
        lk_ovf  = is_space ? code_overflow_reg : code_overflow_next;
        ch = (lk_ovf || (lk_len == 4'd0)) ? mtd_pkg::NO_CHAR
                : mtd_pkg::morse_lookup(lk_len, lk_bits[mtd_pkg::TABLE_BITS-1:0]);

        space_emit  = is_mark && gap_pending_reg;
        letter_emit = (ch != mtd_pkg::NO_CHAR) && (is_space || symbol.end_of_message);

        if (is_mark)
        begin
            gap_pending_next = 1'b0;
            space_run_next   = 3'd0;
        end
        else if (is_space)
        begin
            code_bits_next     = '0;
            code_length_next   = 4'd0;
            code_overflow_next = 1'b0;
            if (ch != mtd_pkg::NO_CHAR)
            begin
                word_seen_next = 1'b1;
            end
            if (space_run_reg < mtd_pkg::SPACE_RUN_MAX)
            begin
                space_run_next = space_run_reg + 3'd1;
            end
            if ((space_run_next >= gap_eff) && word_seen_next)
            begin
                gap_pending_next = 1'b1;
            end
        end

        if (symbol.end_of_message)
        begin
            code_bits_next     = '0;
            code_length_next   = 4'd0;
            code_overflow_next = 1'b0;
            space_run_next     = 3'd0;
            gap_pending_next   = 1'b0;
            word_seen_next     = 1'b0;
        end

        wr_en         = accept && (space_emit || letter_emit);
        wr_entry.two  = space_emit && letter_emit;
        wr_entry.ch_a = space_emit ? mtd_pkg::SPACE_CHAR : ch;
        wr_entry.ch_b = ch;
        wr_entry.last = symbol.end_of_message;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_bits_reg     <= '0;
            code_length_reg   <= 4'd0;
            code_overflow_reg <= 1'b0;
            space_run_reg     <= 3'd0;
            gap_pending_reg   <= 1'b0;
            word_seen_reg     <= 1'b0;
            word_gap_reg      <= mtd_pkg::WORD_GAP_RESET;
        end
        else
        begin
            if (accept)
            begin
                code_bits_reg     <= code_bits_next;
                code_length_reg   <= code_length_next;
                code_overflow_reg <= code_overflow_next;
                space_run_reg     <= space_run_next;
                gap_pending_reg   <= gap_pending_next;
                word_seen_reg     <= word_seen_next;
            end
            if (cfg_valid)
            begin
                word_gap_reg <= cfg_data;
            end
        end
    end

endmodule

// ===== rtl/core/mtd_queue.sv =====
// ----------------------------------------------------------------------------
// mtd_queue
// Short entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module mtd_queue #(
    parameter int DEPTH = mtd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  mtd_pkg::entry_t wr_entry,
    output logic            full,
    input  logic            rd_en,
    output mtd_pkg::entry_t rd_entry,
    output logic            empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mtd_pkg::entry_t mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_wr, do_rd;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && !empty;
    assign rd_entry = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

endmodule

// ===== rtl/core/mtd_back.sv =====
// ----------------------------------------------------------------------------
// mtd_back
// Holds one entry and hands out its one or two result items in order.
// ----------------------------------------------------------------------------
module mtd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  mtd_pkg::entry_t    rd_entry,
    input  logic               queue_empty,
    output logic               rd_en,
    input  logic               pop,
    output logic               empty,
    output mtd_pkg::out_item_t result
);

    mtd_pkg::entry_t entry_reg;
    logic            entry_valid_reg;
    logic            phase_reg;
    logic            done_entry;
    logic            take;

    assign done_entry       = phase_reg || !entry_reg.two;
    assign take             = !entry_valid_reg || (pop && done_entry);
    assign rd_en            = take && !queue_empty;
    assign empty            = !entry_valid_reg;
    assign result.char_code = phase_reg ? entry_reg.ch_b : entry_reg.ch_a;
    assign result.last_char = entry_reg.last && done_entry;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            entry_reg <= rd_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
            phase_reg       <= 1'b0;
        end
        else if (take)
        begin
            entry_valid_reg <= !queue_empty;
            phase_reg       <= 1'b0;
        end
        else if (pop)
        begin
            phase_reg <= 1'b1;
        end
    end

endmodule
